>>> hw/rtl/vsd_pkg.sv
// Shared types and constants of the varint stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package vsd_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TRUNC      = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_TOO_LONG   = 3'd3,
    ST_BAD_MARKER = 3'd4
  } vsd_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [63:0] value_bits;
    vsd_status_e status;
  } out_word_t;

  typedef struct packed {
    logic format_select;
    logic zigzag_signed;
  } vsd_cfg_t;

  localparam logic       CFG_FORMAT = 1'b0;
  localparam logic       CFG_ZIGZAG = 1'b1;

  localparam logic       FMT_LEB    = 1'b0;
  localparam logic       FMT_BINC   = 1'b1;

  localparam logic [3:0] LEB_LAST_POS  = 4'd9;
  localparam logic [6:0] LEB_GROUP     = 7'h7f;
  localparam logic [7:0] BC_MARK_2     = 8'd251;
  localparam logic [7:0] BC_MARK_4     = 8'd252;
  localparam logic [7:0] BC_MARK_8     = 8'd253;

endpackage

`default_nettype wire

>>> hw/rtl/vsd_front.sv
// Front end: accepts stream bytes, tracks the value in progress, classifies each byte.
`timescale 1ns / 1ps
`default_nettype none

module vsd_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              accept_i,
  input  vsd_pkg::in_word_t in_word_i,
  input  wire              format_select_i,
  output logic             push_o,
  output vsd_pkg::out_word_t push_word_o
);
  import vsd_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [3:0]  taken_q, taken_d;
  logic [3:0]  expected_q, expected_d;
  logic        in_value_q, in_value_d;
  logic        err_q, err_d;

  logic [7:0]  b;
  logic [5:0]  leb_sh;
  logic [63:0] leb_merged;
  logic [63:0] bc_merged;
  logic [3:0]  taken_inc;

  always_comb begin
    b          = in_word_i.data_byte;
    leb_sh     = 6'({2'b00, taken_q} * 6'd7);
    leb_merged = acc_q | (64'(b[6:0]) << leb_sh);
    bc_merged  = {acc_q[55:0], b};
    taken_inc  = taken_q + 4'd1;

    acc_d       = acc_q;
    taken_d     = taken_q;
    expected_d  = expected_q;
    in_value_d  = in_value_q;
    err_d       = err_q;
    push_o      = 1'b0;
    push_word_o = '{value_bits: 64'd0, status: ST_OK};

    if (accept_i && !err_q) begin
      if (in_word_i.end_of_data) begin
        if (in_value_q) begin
          push_o             = 1'b1;
          push_word_o.status = ST_TRUNC;
          err_d              = 1'b1;
        end
      end else if (format_select_i == FMT_BINC) begin
        if (!in_value_q) begin
          if (b < BC_MARK_2) begin
            push_o                 = 1'b1;
            push_word_o.value_bits = {56'd0, b};
          end else if (b inside {BC_MARK_2, BC_MARK_4, BC_MARK_8}) begin
            acc_d      = 64'd0;
            taken_d    = 4'd0;
            in_value_d = 1'b1;
            case (b)
              BC_MARK_2: expected_d = 4'd2;
              BC_MARK_4: expected_d = 4'd4;
              default:   expected_d = 4'd8;
            endcase
          end else begin
            push_o             = 1'b1;
            push_word_o.status = ST_BAD_MARKER;
            err_d              = 1'b1;
          end
        end else if (taken_inc >= expected_q) begin
          push_o                 = 1'b1;
          push_word_o.value_bits = bc_merged;
        end else begin
          acc_d   = bc_merged;
          taken_d = taken_inc;
        end
      end else begin
        if (taken_q >= LEB_LAST_POS) begin
          if ((b[6:0] & 7'h7e) != 7'd0) begin
            push_o             = 1'b1;
            push_word_o.status = ST_OVERFLOW;
            err_d              = 1'b1;
          end else if (!b[7]) begin
            push_o                 = 1'b1;
            push_word_o.value_bits = acc_q | {b[0], 63'd0};
          end else begin
            push_o             = 1'b1;
            push_word_o.status = ST_TOO_LONG;
            err_d              = 1'b1;
          end
        end else if (!b[7]) begin
          push_o                 = 1'b1;
          push_word_o.value_bits = leb_merged;
        end else begin
          acc_d      = leb_merged;
          taken_d    = taken_inc;
          in_value_d = 1'b1;
        end
      end

      // any result closes the value in progress
      if (push_o) begin
        acc_d      = 64'd0;
        taken_d    = 4'd0;
        expected_d = 4'd0;
        in_value_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 64'd0;
      taken_q    <= 4'd0;
      expected_q <= 4'd0;
      in_value_q <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      taken_q    <= taken_d;
      expected_q <= expected_d;
      in_value_q <= in_value_d;
      err_q      <= err_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vsd_fifo.sv
// Small result queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module vsd_fifo #(
  parameter int Depth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  vsd_pkg::out_word_t push_word_i,
  input  wire                pop_i,
  output vsd_pkg::out_word_t pop_word_o,
  output logic               full_o,
  output logic               empty_o
);
  import vsd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  out_word_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    full_o     = (cnt_q == CntW'(Depth));
    empty_o    = (cnt_q == '0);
    pop_word_o = mem_q[rd_q];
    wr_d       = wr_q;
    rd_d       = rd_q;
    cnt_d      = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/vsd_back.sv
// Back end: applies zigzag to finished values and holds the output register.
`timescale 1ns / 1ps
`default_nettype none

module vsd_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                empty_i,
  input  vsd_pkg::out_word_t pop_word_i,
  input  wire                zigzag_signed_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output vsd_pkg::out_word_t out_word_o
);
  import vsd_pkg::*;

  logic      valid_q, valid_d;
  out_word_t word_q, word_d;
  logic [63:0] v;

  always_comb begin
    pop_o   = !empty_i && (!valid_q || !out_stall_i);
    v       = pop_word_i.value_bits;
    word_d  = pop_word_i;
    if (zigzag_signed_i && pop_word_i.status == ST_OK) begin
      word_d.value_bits = (v >> 1) ^ {64{v[0]}};
    end
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q <= word_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

`default_nettype wire

>>> hw/rtl/varint_stream_decoder_unit.sv
// Top level of the varint stream decoder: config registers, front, queue, back.
//
// Input channel: one stream word (data_byte, end_of_data) per accepted word,
// taken when in_valid_i is high and in_stall_o is low. One word per cycle is
// sustained; in_stall_o rises only when the result queue is full.
// Output channel: one word (value_bits, status) per finished value or error,
// delivered when out_valid_o is high and out_stall_i is low.
// Result path: the input word that completes a result is written into the result
// queue, then into the output register that drives out_valid_o.
// Throughput: one input word per cycle while the result queue is not full, set by the
// combinational shift and merge in the front end.
// The first error is reported once; afterwards every input word is consumed
// with no result until reset.
// Config: write cfg_we_i with cfg_idx_i (0 format, 1 zigzag) while idle.
// Reset clears the decoder state, the queue and the config registers.
// When the receiver stalls, the output word holds, the queue fills, and then
// the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module varint_stream_decoder_unit #(
  parameter int FifoDepth = 2
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  vsd_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output vsd_pkg::out_word_t out_word_o,
  input  wire                cfg_we_i,
  input  wire                cfg_idx_i,
  input  wire                cfg_data_i
);
  import vsd_pkg::*;

  vsd_cfg_t  cfg_q, cfg_d;
  logic      push, pop, full, empty;
  out_word_t push_word, pop_word;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FORMAT: cfg_d.format_select = cfg_data_i;
        CFG_ZIGZAG: cfg_d.zigzag_signed = cfg_data_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = full;

  vsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_valid_i && !full),
    .in_word_i      (in_word_i),
    .format_select_i(cfg_q.format_select),
    .push_o         (push),
    .push_word_o    (push_word)
  );

  vsd_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_word_i(push_word),
    .pop_i      (pop),
    .pop_word_o (pop_word),
    .full_o     (full),
    .empty_o    (empty)
  );

  vsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .pop_word_i     (pop_word),
    .zigzag_signed_i(cfg_q.zigzag_signed),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_word_o     (out_word_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/vsd_checker.sv
// Port-level checks on the varint stream decoder and their bind.
`timescale 1ns / 1ps
`default_nettype none

module vsd_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input vsd_pkg::out_word_t out_word_o
);
  import vsd_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |-> out_word_o.value_bits == 64'd0)
    else $error("error word carries a nonzero value");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_word_o.status != ST_OK |=> !out_valid_o)
    else $error("word delivered after an error");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled while output register empty");

endmodule

bind varint_stream_decoder_unit vsd_checker u_vsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

`default_nettype wire

>>> tb/varint_stream_decoder_unit_tb.sv
// Testbench for varint_stream_decoder_unit: directed and random streams vs a local decoder.
`timescale 1ns / 1ps

module varint_stream_decoder_unit_tb;
  import vsd_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_idx_i = 1'b0;
  logic      cfg_data_i = 1'b0;

  varint_stream_decoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // decoder copy, updated on every accepted input word
  logic        fmt_sel = FMT_LEB;
  logic        zz_on = 1'b0;
  logic [63:0] acc_q = '0;
  logic [3:0]  taken_q = '0;
  logic [3:0]  need_q = '0;
  logic        in_val_q = 1'b0;
  logic        err_q = 1'b0;
  out_word_t   expected_words[$];

  out_word_t   want;
  int          n_mismatch = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          hold_cycles = 0;
  logic        cur_fmt = FMT_LEB;
  logic        part_fmt = FMT_LEB;
  int          part_left = 0;

  task automatic drop_value();
    acc_q    = '0;
    taken_q  = '0;
    need_q   = '0;
    in_val_q = 1'b0;
  endtask

  task automatic finish_value(input logic [63:0] v);
    out_word_t w;
    w.value_bits = zz_on ? ((v >> 1) ^ (64'd0 - {63'd0, v[0]})) : v;
    w.status     = ST_OK;
    expected_words.insert(expected_words.size(), w);
    drop_value();
  endtask

  task automatic raise_error(input vsd_status_e code);
    out_word_t w;
    w.value_bits = '0;
    w.status     = code;
    expected_words.insert(expected_words.size(), w);
    drop_value();
    err_q = 1'b1;
  endtask

  task automatic decode_word(input in_word_t w);
    logic [7:0] b;
    b = w.data_byte;
    if (err_q) begin
    end else if (w.end_of_data) begin
      if (in_val_q) raise_error(ST_TRUNC);
    end else if (fmt_sel == FMT_BINC) begin
      if (!in_val_q) begin
        if (b < BC_MARK_2) begin
          finish_value({56'd0, b});
        end else if (b == BC_MARK_2 || b == BC_MARK_4 || b == BC_MARK_8) begin
          acc_q    = '0;
          taken_q  = '0;
          need_q   = (b == BC_MARK_2) ? 4'd2 : (b == BC_MARK_4) ? 4'd4 : 4'd8;
          in_val_q = 1'b1;
        end else begin
          raise_error(ST_BAD_MARKER);
        end
      end else begin
        acc_q   = {acc_q[55:0], b};
        taken_q = taken_q + 4'd1;
        if (taken_q >= need_q) finish_value(acc_q);
      end
    end else if (taken_q >= LEB_LAST_POS) begin
      // last group: only bit 0 may be set
      if (b[6:1] != 6'd0) begin
        raise_error(ST_OVERFLOW);
      end else begin
        acc_q[63] = acc_q[63] | b[0];
        if (!b[7]) finish_value(acc_q);
        else raise_error(ST_TOO_LONG);
      end
    end else begin
      acc_q = acc_q | ({57'd0, b[6:0]} << (7 * taken_q));
      if (!b[7]) begin
        finish_value(acc_q);
      end else begin
        taken_q  = taken_q + 4'd1;
        in_val_q = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FORMAT) fmt_sel = cfg_data_i;
        else zz_on = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) decode_word(in_word_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: value_bits %h status %0d", out_word_o.value_bits,
                 out_word_o.status);
          n_mismatch++;
        end else begin
          want = expected_words.pop_front();
          if (out_word_o.value_bits !== want.value_bits) begin
            $error("value_bits: expected %h, got %h", want.value_bits, out_word_o.value_bits);
            n_mismatch++;
          end
          if (out_word_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word_o.status);
            n_mismatch++;
          end
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: long hold-off when requested, else random stalls
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall_i <= (sink_stall_pct > 0) && (int'($urandom_range(99)) < sink_stall_pct);
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eod);
    @(negedge clk_i);
    while (src_idle_pct > 0 && int'($urandom_range(99)) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{data_byte: b, end_of_data: eod};
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic set_mode(input logic f, input logic z);
    wait_quiet();
    write_reg(CFG_FORMAT, f);
    write_reg(CFG_ZIGZAG, z);
    cur_fmt = f;
  endtask

  function automatic logic [63:0] rand64();
    int unsigned len;
    logic [63:0] v;
    len = $urandom_range(64);
    v   = {$urandom, $urandom};
    if (len < 64) v = v & ((64'd1 << len) - 64'd1);
    return v;
  endfunction

  // pad adds zero groups, capped at ten bytes
  task automatic send_leb(input logic [63:0] v, input int pad);
    int n;
    logic [63:0] rest;
    n    = 1;
    rest = v >> 7;
    while (rest != 0) begin
      n++;
      rest = rest >> 7;
    end
    n = n + pad;
    if (n > 10) n = 10;
    for (int i = 0; i < n; i++) send_word({i < n - 1, 7'(v >> (7 * i))}, 1'b0);
  endtask

  // width 0 picks the shortest form; 2, 4, 8 send the low bytes after a marker
  task automatic send_binc(input logic [63:0] v, input int width);
    int w;
    w = width;
    if (w == 0)
      w = (v < 64'(BC_MARK_2)) ? 1 : (v <= 64'hffff) ? 2 : (v <= 64'hffff_ffff) ? 4 : 8;
    if (w == 1) begin
      send_word(v[7:0], 1'b0);
    end else begin
      send_word((w == 2) ? BC_MARK_2 : (w == 4) ? BC_MARK_4 : BC_MARK_8, 1'b0);
      for (int i = w - 1; i >= 0; i--) send_word(v[8 * i +: 8], 1'b0);
    end
  endtask

  task automatic send_value(input logic [63:0] v);
    int w;
    if (cur_fmt == FMT_BINC) begin
      w = 0;
      if ($urandom_range(3) == 0) w = 2 << $urandom_range(2);
      send_binc(v, w);
    end else begin
      send_leb(v, ($urandom_range(3) == 0) ? int'($urandom_range(9)) : 0);
    end
  endtask

  // start a value and stop part way, so a mode write lands mid-value
  task automatic leave_partial();
    int n;
    part_fmt = cur_fmt;
    if (cur_fmt == FMT_LEB) begin
      repeat ($urandom_range(1, 8)) send_word({1'b1, 7'($urandom)}, 1'b0);
    end else begin
      n = 2 << $urandom_range(2);
      send_word((n == 2) ? BC_MARK_2 : (n == 4) ? BC_MARK_4 : BC_MARK_8, 1'b0);
      part_left = n - int'($urandom_range(n - 1));
      repeat (n - part_left) send_word(8'($urandom), 1'b0);
    end
  endtask

  task automatic close_partial();
    if (cur_fmt == FMT_LEB) send_word({1'b0, 7'($urandom)}, 1'b0);
    else if (part_fmt == FMT_LEB) send_word(8'($urandom), 1'b0);
    else repeat (part_left) send_word(8'($urandom), 1'b0);
  endtask

  task automatic test_leb_extremes();
    set_mode(FMT_LEB, 1'b0);
    send_leb(64'd0, 0);
    send_leb(64'd127, 0);
    send_leb(64'd128, 0);
    send_leb('1, 0);
    send_leb(64'h8000_0000_0000_0000, 0);
    send_leb(64'd0, 9);
    send_word(8'hff, 1'b1);
  endtask

  task automatic test_bincode_markers();
    set_mode(FMT_BINC, 1'b0);
    send_binc(64'd250, 0);
    send_binc(64'hffff, 2);
    send_binc(64'hffff_ffff, 4);
    send_binc('1, 8);
    send_binc(64'd0, 8);
  endtask

  task automatic test_zigzag();
    set_mode(FMT_BINC, 1'b1);
    send_binc(64'd0, 0);
    send_binc(64'd1, 0);
    send_binc(64'd2, 0);
    send_binc('1, 8);
    set_mode(FMT_LEB, 1'b1);
    send_leb(64'hffff_ffff_ffff_fffe, 0);
  endtask

  // LEB to bincode, bincode to bincode, bincode to LEB, LEB to LEB
  task automatic test_mode_switch();
    set_mode(FMT_LEB, 1'b0);
    for (int i = 0; i < 4; i++) begin
      leave_partial();
      set_mode((i < 2) ? FMT_BINC : FMT_LEB, ~i[0]);
      close_partial();
    end
  endtask

  task automatic run_phase(input int src_pct, input int sink_pct, input logic f,
                           input logic z, input int n_words);
    int stop_at;
    int pick;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    set_mode(f, z);
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_word(8'($urandom), 1'b1);
      end else if (pick < 8) begin
        leave_partial();
        set_mode(1'($urandom), 1'($urandom));
        close_partial();
      end else begin
        send_value(rand64());
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(0, 0, FMT_LEB, 1'b0, 400);
    run_phase(53, 0, FMT_BINC, 1'b0, 400);
    run_phase(0, 53, FMT_LEB, 1'b1, 400);
    run_phase(14, 14, FMT_BINC, 1'b1, 400);
  endtask

  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_mode(FMT_BINC, 1'($urandom));
    repeat (5) send_word(8'($urandom_range(250)), 1'b0);
    hold_cycles = 300;
    repeat (40) send_word(8'($urandom_range(250)), 1'b0);
  endtask

  // one error per run, since it holds until reset
  task automatic test_error_latch();
    vsd_status_e kind;
    kind = vsd_status_e'($urandom_range(ST_TRUNC, ST_BAD_MARKER));
    src_idle_pct   = 14;
    sink_stall_pct = 14;
    case (kind)
      ST_TRUNC: begin
        set_mode(1'($urandom), 1'($urandom));
        leave_partial();
        send_word(8'($urandom), 1'b1);
      end
      ST_OVERFLOW: begin
        set_mode(FMT_LEB, 1'($urandom));
        repeat (9) send_word({1'b1, 7'($urandom)}, 1'b0);
        send_word({1'($urandom), 6'($urandom_range(1, 63)), 1'($urandom)}, 1'b0);
      end
      ST_TOO_LONG: begin
        set_mode(FMT_LEB, 1'($urandom));
        repeat (9) send_word({1'b1, 7'($urandom)}, 1'b0);
        send_word({1'b1, 6'd0, 1'($urandom)}, 1'b0);
      end
      default: begin
        set_mode(FMT_BINC, 1'($urandom));
        send_word(8'($urandom_range(254, 255)), 1'b0);
      end
    endcase
    repeat (30) send_word(8'($urandom), 1'($urandom_range(3) == 0));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_leb_extremes();
    test_bincode_markers();
    test_zigzag();
    test_mode_switch();
    test_random_traffic();
    test_backpressure();
    test_error_latch();
    wait_quiet();
    if (n_mismatch == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/vsd_pkg.sv
hw/rtl/vsd_front.sv
hw/rtl/vsd_fifo.sv
hw/rtl/vsd_back.sv
hw/rtl/varint_stream_decoder_unit.sv
hw/rtl/vsd_checker.sv
tb/varint_stream_decoder_unit_tb.sv
